// ===== hw/rtl/sv39w_pkg.sv =====
`default_nettype none

package sv39w_pkg;

	localparam int TABLE_PAGES = 16;
	localparam int VPN_W       = 9;
	localparam int FLAG_W      = 10;
	localparam int PAGE_SHIFT  = 12;
	localparam int PPN_W       = 44;
	localparam int ENTRY_W     = PPN_W + FLAG_W;
	localparam int VA_W        = 39;
	localparam int PA_W        = 56;
	localparam int PAGE_W      = $clog2(TABLE_PAGES);
	localparam int ADDR_W      = PAGE_W + VPN_W;
	localparam int STORE_DEPTH = TABLE_PAGES * (1 << VPN_W);
	localparam int NFP_W       = $clog2(TABLE_PAGES + 1);

	localparam logic [PPN_W-1:0]  BASE_RESET = PPN_W'(524288);
	localparam logic [FLAG_W-1:0] BIT_V      = FLAG_W'(1);
	localparam logic [FLAG_W-1:0] BITS_AD    = FLAG_W'(8'hC0);

	typedef enum logic [1:0] {
		ST_OK,
		ST_MISSING,
		ST_NO_PAGES,
		ST_OUTSIDE
	} status_t;

	typedef struct packed {
		logic       clr_step;
		logic       load;
		logic       rd;
		logic       wr_inter;
		logic       wr_leaf;
		logic       take_next;
		logic       cap_leaf;
		logic       fail;
		status_t    fail_code;
		logic       publish;
		logic [1:0] level;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic func;
		logic ent_valid;
		logic ent_inside;
		logic pages_left;
	} sts_t;

	function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va,
		input logic [1:0] level);
		logic [VPN_W-1:0] v;
		case (level)
			2'd2: v = va[PAGE_SHIFT + 2 * VPN_W +: VPN_W];
			2'd1: v = va[PAGE_SHIFT + VPN_W +: VPN_W];
			default: v = va[PAGE_SHIFT +: VPN_W];
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sv39w_if.sv =====
`default_nettype none

interface sv39w_req_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [sv39w_pkg::VA_W-1:0]  virt_addr;
	logic [sv39w_pkg::PA_W-1:0]  phys_addr;
	logic [sv39w_pkg::FLAG_W-1:0] leaf_flags;

	modport source (output valid, func, virt_addr, phys_addr, leaf_flags, input ready);
	modport sink (input valid, func, virt_addr, phys_addr, leaf_flags, output ready);
endinterface

interface sv39w_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [sv39w_pkg::ENTRY_W-1:0] leaf_entry;

	modport source (output valid, status, leaf_entry, input ready);
	modport sink (input valid, status, leaf_entry, output ready);
endinterface

interface sv39w_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [sv39w_pkg::PPN_W-1:0] store_base_ppn;

	modport source (output valid, store_base_ppn, input ready);
	modport sink (input valid, store_base_ppn, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sv39w_dpath.sv =====
`default_nettype none

module sv39w_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          func,
	input  wire logic [sv39w_pkg::VA_W-1:0]    virt_addr,
	input  wire logic [sv39w_pkg::PA_W-1:0]    phys_addr,
	input  wire logic [sv39w_pkg::FLAG_W-1:0]  leaf_flags,
	input  wire logic                          cfg_valid,
	input  wire logic [sv39w_pkg::PPN_W-1:0]   cfg_data,
	output logic                               cfg_ready,
	input  wire sv39w_pkg::cmd_t               cmd,
	output sv39w_pkg::sts_t                    sts,
	output logic [1:0]                         status,
	output logic [sv39w_pkg::ENTRY_W-1:0]      leaf_entry
);

	localparam logic [sv39w_pkg::ADDR_W-1:0] CLR_LAST =
		sv39w_pkg::ADDR_W'(sv39w_pkg::STORE_DEPTH - 1);

	logic [sv39w_pkg::ENTRY_W-1:0] mem [sv39w_pkg::STORE_DEPTH];

	logic [sv39w_pkg::PPN_W-1:0]   base_q;
	logic [sv39w_pkg::ADDR_W-1:0]  clr_cnt_q;
	logic [sv39w_pkg::NFP_W-1:0]   nfp_q;
	logic [sv39w_pkg::PAGE_W-1:0]  page_q;
	logic                          func_q;
	logic [sv39w_pkg::VA_W-1:0]    va_q;
	logic [sv39w_pkg::PA_W-1:0]    pa_q;
	logic [sv39w_pkg::FLAG_W-1:0]  flags_q;
	logic [sv39w_pkg::ENTRY_W-1:0] rdata_q;
	sv39w_pkg::status_t            st_w_q;
	logic [sv39w_pkg::ENTRY_W-1:0] leaf_w_q;
	logic [1:0]                    status_q;
	logic [sv39w_pkg::ENTRY_W-1:0] leaf_q;

	logic [sv39w_pkg::ADDR_W-1:0]  addr;
	logic [sv39w_pkg::ENTRY_W-1:0] wdata;
	logic                          wr_en;
	logic [sv39w_pkg::PPN_W-1:0]   off;
	logic [sv39w_pkg::ENTRY_W-1:0] inter_entry;
	logic [sv39w_pkg::ENTRY_W-1:0] leaf_val;

	assign cfg_ready   = 1'b1;
	assign off         = rdata_q[sv39w_pkg::FLAG_W +: sv39w_pkg::PPN_W] - base_q;
	assign inter_entry = {base_q + sv39w_pkg::PPN_W'(nfp_q), sv39w_pkg::BIT_V};
	assign leaf_val    = {pa_q[sv39w_pkg::PAGE_SHIFT +: sv39w_pkg::PPN_W],
		flags_q | sv39w_pkg::BITS_AD};

	always_comb begin
		if (cmd.clr_step) begin
			addr = clr_cnt_q;
		end else begin
			addr = {page_q, sv39w_pkg::vpn_of(va_q, cmd.level)};
		end
		if (cmd.wr_inter) begin
			wdata = inter_entry;
		end else if (cmd.wr_leaf) begin
			wdata = leaf_val;
		end else begin
			wdata = '0;
		end
		wr_en = cmd.clr_step | cmd.wr_inter | cmd.wr_leaf;
	end

	always_comb begin
		sts.clr_done   = (clr_cnt_q == CLR_LAST);
		sts.func       = func_q;
		sts.ent_valid  = rdata_q[0];
		sts.ent_inside = (off < sv39w_pkg::PPN_W'(sv39w_pkg::TABLE_PAGES));
		sts.pages_left = (nfp_q < sv39w_pkg::NFP_W'(sv39w_pkg::TABLE_PAGES));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= sv39w_pkg::BASE_RESET;
			clr_cnt_q <= '0;
			nfp_q     <= sv39w_pkg::NFP_W'(1);
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			if (cmd.clr_step && !sts.clr_done) begin
				clr_cnt_q <= clr_cnt_q + sv39w_pkg::ADDR_W'(1);
			end
			if (cmd.wr_inter) begin
				nfp_q <= nfp_q + sv39w_pkg::NFP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			va_q    <= virt_addr;
			pa_q    <= phys_addr;
			flags_q <= leaf_flags;
			page_q  <= '0;
		end
		if (cmd.take_next) begin
			page_q <= off[sv39w_pkg::PAGE_W-1:0];
		end
		if (cmd.wr_inter) begin
			page_q <= nfp_q[sv39w_pkg::PAGE_W-1:0];
		end
		if (cmd.fail) begin
			st_w_q   <= cmd.fail_code;
			leaf_w_q <= '0;
		end
		if (cmd.wr_leaf) begin
			st_w_q   <= sv39w_pkg::ST_OK;
			leaf_w_q <= leaf_val;
		end
		if (cmd.cap_leaf) begin
			st_w_q   <= sv39w_pkg::ST_OK;
			leaf_w_q <= rdata_q;
		end
		if (cmd.publish) begin
			status_q <= st_w_q;
			leaf_q   <= leaf_w_q;
		end
	end

	assign status     = status_q;
	assign leaf_entry = leaf_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sv39w_ctrl.sv =====
`default_nettype none

module sv39w_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output sv39w_pkg::cmd_t      cmd,
	input  wire sv39w_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_LEAF_WR,
		S_DONE
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] level_q, level_d;
	logic       rsp_valid_q;

	always_comb begin
		state_d       = state_q;
		level_d       = level_q;
		req_ready     = 1'b0;
		cmd           = '0;
		cmd.fail_code = sv39w_pkg::ST_OK;
		cmd.level     = level_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					level_d  = 2'd2;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (level_q == 2'd0) begin
					cmd.cap_leaf = 1'b1;
					state_d      = S_DONE;
				end else if (sts.ent_valid && !sts.ent_inside) begin
					cmd.fail      = 1'b1;
					cmd.fail_code = sv39w_pkg::ST_OUTSIDE;
					state_d       = S_DONE;
				end else if (!sts.ent_valid && !sts.func) begin
					cmd.fail      = 1'b1;
					cmd.fail_code = sv39w_pkg::ST_MISSING;
					state_d       = S_DONE;
				end else if (!sts.ent_valid && !sts.pages_left) begin
					cmd.fail      = 1'b1;
					cmd.fail_code = sv39w_pkg::ST_NO_PAGES;
					state_d       = S_DONE;
				end else begin
					cmd.take_next = sts.ent_valid;
					cmd.wr_inter  = !sts.ent_valid;
					level_d       = level_q - 2'd1;
					if (level_q == 2'd1 && sts.func) begin
						state_d = S_LEAF_WR;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_LEAF_WR: begin
				cmd.wr_leaf = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			level_q     <= 2'd2;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_claim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_inter |-> sts.pages_left && level_q != 2'd0)
		else $error("table claimed with no page left or at leaf level");

	a_one_mem_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.rd, cmd.wr_inter, cmd.wr_leaf}))
		else $error("more than one store access in a cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !rsp_valid_q || rsp_ready)
		else $error("result published over a pending transfer");

	a_leaf_write_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_leaf |-> sts.func && level_q == 2'd0)
		else $error("leaf written outside a map at level zero");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !req_ready)
		else $error("request accepted during clearing pass");

endmodule

`default_nettype wire

// ===== hw/rtl/sv39_page_table_walk_and_map.sv =====
`default_nettype none

// channel | dir | payload                                     | transfer
// req     | in  | func, virt_addr, phys_addr, leaf_flags      | valid & ready
// rsp     | out | status, leaf_entry                          | valid & ready
// cfg     | in  | store_base_ppn                              | valid & ready
//
// Each level is a store read followed by an evaluate; a map writes its leaf in
// place of the level-0 read and evaluate. The next request can transfer in the
// cycle after the result is published, and none is accepted before that.
// After reset a clearing pass zeroes all 8192 store entries, taking cfg
// writes but no request; a stalled rsp parks the next item until it frees.

module sv39_page_table_walk_and_map (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sv39w_req_if.sink    req,
	sv39w_rsp_if.source  rsp,
	sv39w_cfg_if.sink    cfg
);

	sv39w_pkg::cmd_t cmd;
	sv39w_pkg::sts_t sts;

	sv39w_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sv39w_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (req.func),
		.virt_addr  (req.virt_addr),
		.phys_addr  (req.phys_addr),
		.leaf_flags (req.leaf_flags),
		.cfg_valid  (cfg.valid),
		.cfg_data   (cfg.store_base_ppn),
		.cfg_ready  (cfg.ready),
		.cmd        (cmd),
		.sts        (sts),
		.status     (rsp.status),
		.leaf_entry (rsp.leaf_entry)
	);

endmodule

`default_nettype wire
